// ===== rtl/tcpq_pkg.sv =====
package tcpq_pkg;

	localparam int CLASS_DEPTH = 16;
	localparam int ID_WIDTH    = 16;

	localparam int NUM_CLASSES = 3;

	localparam int FUNC_W   = 1;
	localparam int CLASS_W  = 2;
	localparam int PID_W    = 16;
	localparam int STATUS_W = 3;
	localparam int TOTAL_W  = 6;

	// stored id bits: the id field is kept to its low ID_WIDTH bits
	localparam int ID_W  = (ID_WIDTH < PID_W) ? ID_WIDTH : PID_W;
	localparam int CNT_W = $clog2(CLASS_DEPTH + 1);
	localparam int SUM_W = CNT_W + 2;

	localparam logic [FUNC_W-1:0] FN_ENQUEUE = 1'b0;
	localparam logic [FUNC_W-1:0] FN_SERVE   = 1'b1;

	localparam logic [CLASS_W-1:0] CLS_GENERAL = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_SENIOR  = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_VIP     = 2'd2;
	localparam logic [CLASS_W-1:0] CLS_INVALID = 2'd3;

	typedef enum logic [STATUS_W-1:0] {
		ST_ENQUEUED = 3'd0,
		ST_SERVED   = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_INVALID  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		logic enq;
		logic deq;
	} queue_ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             full;
		logic             nonempty;
		logic [ID_W-1:0]  head_id;
	} queue_status_t;

endpackage

// ===== rtl/tcpq_ifs.sv =====
interface tcpq_req_if import tcpq_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [CLASS_W-1:0] passenger_class;
	logic [PID_W-1:0]   passenger_id;

	modport source (output valid, func, passenger_class, passenger_id, input ready);
	modport sink   (input valid, func, passenger_class, passenger_id, output ready);
endinterface

interface tcpq_rsp_if import tcpq_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PID_W-1:0]    served_id;
	logic [CLASS_W-1:0]  served_class;
	logic [TOTAL_W-1:0]  total_waiting;

	modport source (output valid, status, served_id, served_class, total_waiting, input ready);
	modport sink   (input valid, status, served_id, served_class, total_waiting, output ready);
endinterface

// ===== rtl/tcpq_cell.sv =====
module tcpq_cell import tcpq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  queue_ctl_t      ctl,
	input  logic            prev_valid,
	input  logic            next_valid,
	input  logic [ID_W-1:0] next_id,
	input  logic [ID_W-1:0] in_id,
	output logic            valid,
	output logic [ID_W-1:0] id
);

	logic            valid_q;
	logic [ID_W-1:0] id_q;

	// enqueue lands in the first empty cell; dequeue shifts toward the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.deq) begin
			valid_q <= next_valid;
		end else if (ctl.enq && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.deq) begin
			id_q <= next_id;
		end else if (ctl.enq && !valid_q && prev_valid) begin
			id_q <= in_id;
		end
	end

	assign valid = valid_q;
	assign id    = id_q;

endmodule

// ===== rtl/tcpq_class_fifo.sv =====
module tcpq_class_fifo import tcpq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  queue_ctl_t      ctl,
	input  logic [ID_W-1:0] in_id,
	output queue_status_t   st
);

	logic [CLASS_DEPTH-1:0] cell_valid;
	logic [ID_W-1:0]        cell_id [CLASS_DEPTH];
	logic [CNT_W-1:0]       count_q;

	for (genvar i = 0; i < CLASS_DEPTH; i++) begin : g_cell
		logic            prev_valid;
		logic            next_valid;
		logic [ID_W-1:0] next_id;

		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_valid = cell_valid[i-1];
		end

		if (i == CLASS_DEPTH - 1) begin : g_tail
			assign next_valid = 1'b0;
			assign next_id    = '0;
		end else begin : g_link
			assign next_valid = cell_valid[i+1];
			assign next_id    = cell_id[i+1];
		end

		tcpq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_valid (prev_valid),
			.next_valid (next_valid),
			.next_id    (next_id),
			.in_id      (in_id),
			.valid      (cell_valid[i]),
			.id         (cell_id[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.enq) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.deq) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign st.count    = count_q;
	assign st.full     = (count_q == CNT_W'(CLASS_DEPTH));
	assign st.nonempty = cell_valid[0];
	assign st.head_id  = cell_id[0];

endmodule

// ===== rtl/three_class_priority_queue_unit.sv =====
// Strict priority queue over three classes (general, senior, VIP), one FIFO per
// class built as a chain of CLASS_DEPTH shift cells. Each request item is an
// enqueue (class 3 is rejected, a full class reports full) or a serve, which
// returns the oldest id of the highest non-empty class. Every request yields
// exactly one response item with status, served id and class (zero unless
// served) and the total waiting after the step. One request per clock: the
// cell chains update in the cycle the item is accepted and the response sits
// in an output register, so a request is taken whenever that register is free
// or being drained; the response is valid in the cycle after acceptance.
module three_class_priority_queue_unit import tcpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tcpq_req_if.sink   request,
	tcpq_rsp_if.source response
);

	queue_ctl_t    ctl [NUM_CLASSES];
	queue_status_t qs  [NUM_CLASSES];

	logic                accept;
	logic [ID_W-1:0]     in_id;
	status_t             status_d;
	logic [PID_W-1:0]    served_id_d;
	logic [CLASS_W-1:0]  served_class_d;
	logic [TOTAL_W-1:0]  total_d;
	logic                sel_full;
	logic                any_ready;
	logic [ID_W-1:0]     pick_id;
	logic [CLASS_W-1:0]  pick_cls;
	logic [SUM_W-1:0]    sum_now;
	logic [SUM_W-1:0]    sum_next;

	logic                out_valid_q;
	status_t             status_q;
	logic [PID_W-1:0]    served_id_q;
	logic [CLASS_W-1:0]  served_class_q;
	logic [TOTAL_W-1:0]  total_q;

	assign request.ready = !out_valid_q || response.ready;
	assign accept        = request.valid && request.ready;
	assign in_id         = request.passenger_id[ID_W-1:0];

	for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_class
		tcpq_class_fifo u_fifo (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl[c]),
			.in_id  (in_id),
			.st     (qs[c])
		);
	end

	always_comb begin
		sel_full  = 1'b0;
		any_ready = 1'b0;
		pick_id   = '0;
		pick_cls  = CLS_GENERAL;
		sum_now   = '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			sum_now = sum_now + SUM_W'(qs[c].count);
			if (request.passenger_class == CLASS_W'(c)) begin
				sel_full = qs[c].full;
			end
			// ascending scan: highest non-empty class wins
			if (qs[c].nonempty) begin
				any_ready = 1'b1;
				pick_id   = qs[c].head_id;
				pick_cls  = CLASS_W'(c);
			end
		end

		for (int c = 0; c < NUM_CLASSES; c++) begin
			ctl[c] = '0;
		end
		status_d       = ST_EMPTY;
		served_id_d    = '0;
		served_class_d = CLS_GENERAL;
		sum_next       = sum_now;

		if (request.func == FN_ENQUEUE) begin
			if (request.passenger_class == CLS_INVALID) begin
				status_d = ST_INVALID;
			end else if (sel_full) begin
				status_d = ST_FULL;
			end else begin
				status_d = ST_ENQUEUED;
				sum_next = sum_now + SUM_W'(1);
				for (int c = 0; c < NUM_CLASSES; c++) begin
					ctl[c].enq = accept && (request.passenger_class == CLASS_W'(c));
				end
			end
		end else if (any_ready) begin
			status_d       = ST_SERVED;
			served_id_d    = PID_W'(pick_id);
			served_class_d = pick_cls;
			sum_next       = sum_now - SUM_W'(1);
			for (int c = 0; c < NUM_CLASSES; c++) begin
				ctl[c].deq = accept && (pick_cls == CLASS_W'(c));
			end
		end

		total_d = TOTAL_W'(sum_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q       <= status_d;
			served_id_q    <= served_id_d;
			served_class_q <= served_class_d;
			total_q        <= total_d;
		end
	end

	assign response.valid         = out_valid_q;
	assign response.status        = status_q;
	assign response.served_id     = served_id_q;
	assign response.served_class  = served_class_q;
	assign response.total_waiting = total_q;

`ifndef NO_ASSERTIONS
	a_accept_gives_response: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> response.valid)
		else $error("accepted request produced no response");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		!((ctl[0].enq && qs[0].full) || (ctl[1].enq && qs[1].full)
			|| (ctl[2].enq && qs[2].full)))
		else $error("enqueue into a full class");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!((ctl[0].deq && !qs[0].nonempty) || (ctl[1].deq && !qs[1].nonempty)
			|| (ctl[2].deq && !qs[2].nonempty)))
		else $error("serve from an empty class");

	a_count_matches_head: assert property (@(posedge clk) disable iff (!arst_n)
		((qs[0].count != '0) == qs[0].nonempty) && ((qs[1].count != '0) == qs[1].nonempty)
			&& ((qs[2].count != '0) == qs[2].nonempty))
		else $error("class count disagrees with cell chain");

	a_served_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(response.valid && (status_q != ST_SERVED))
			|-> (served_id_q == '0 && served_class_q == CLS_GENERAL))
		else $error("served fields set on a non-serve response");
`endif

endmodule
